@@ sv/assert_macros.svh @@
// Assertion macros shared by the hasher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ sv/sha512_pkg.sv @@
// Types, constants and round functions of the SHA-512 hasher.
`timescale 1ns / 1ps
`default_nettype none
package sha512_pkg;
  localparam int WordW = 64;
  localparam int BlockWords = 16;
  localparam int Rounds = 80;
  localparam logic [7:0] PadByte = 8'h80;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PAD, ST_LEN_HI, ST_LEN_LO, ST_ROUND, ST_ADD, ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    WSRC_INPUT, WSRC_PAD, WSRC_ZERO, WSRC_LEN
  } wsrc_t;

  typedef struct packed {
    logic   push;
    wsrc_t  wsrc;
    logic   start;
    logic   round;
    logic   add;
    logic   out_adv;
    logic   clear;
  } cmd_t;

  typedef struct packed {
    logic       block_full;
    logic [3:0] fill;
    logic       rounds_done;
    logic       out_done;
  } stat_t;

  localparam logic [63:0] InitHash [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
    64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};

  localparam logic [63:0] RoundK [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};

  function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
    rotr = (x >> n) | (x << (64 - n));
  endfunction
endpackage
`default_nettype wire

@@ sv/sha512_hasher_unit.sv @@
// Top level of the streaming SHA-512 hasher.
// Channel | Dir | Ports
// in      | in  | in_valid in_ready in_message_word in_byte_count in_last_word
// out     | out | out_valid out_ready out_digest_word out_digest_index out_digest_last
// The 16th word of a block starts the rounds, followed by the add step.
// The final word adds padding words (one a cycle outside rounds), a possible extra
// block, then eight output beats. Input is held off during rounds and output.
// Synchronous reset restores the initial hash; the block also returns there after a digest.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sha512_hasher_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [63:0] in_message_word,
  input  wire logic [3:0]  in_byte_count,
  input  wire logic        in_last_word,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_digest_word,
  output logic [2:0]       out_digest_index,
  output logic             out_digest_last
);
  import sha512_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  sha512_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_last_word, .in_byte_count,
    .out_valid, .out_ready, .stat, .cmd
  );

  sha512_dp u_dp (
    .clk, .rst_n, .cmd, .in_message_word, .in_byte_count, .in_last_word, .stat,
    .out_digest_word, .out_digest_index, .out_digest_last
  );

  `ASSERT_IMPL(a_no_in_out, clk, rst_n, out_valid, !in_ready)
  `ASSERT_IMPL(a_no_push_round, clk, rst_n, cmd.round, !cmd.push)
  `ASSERT_NEXT(a_last_clears, clk, rst_n, out_valid && out_ready && out_digest_last,
    !out_valid && out_digest_index == 3'd0)
endmodule
`default_nettype wire

@@ sv/sha512_ctrl.sv @@
// Sequencer: word intake, padding, rounds and digest output.
`timescale 1ns / 1ps
`default_nettype none
module sha512_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             in_last_word,
  input  wire logic [3:0]       in_byte_count,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire sha512_pkg::stat_t stat,
  output sha512_pkg::cmd_t      cmd
);
  import sha512_pkg::*;

  state_t state_r, state_nxt, ret_r, ret_nxt;
  logic   need_pad_r, need_pad_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      ret_r      <= ST_IDLE;
      need_pad_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      ret_r      <= ret_nxt;
      need_pad_r <= need_pad_nxt;
    end
  end

  // full last word sends the 0x80 byte in its own word
  always_comb begin
    state_nxt    = state_r;
    ret_nxt      = ret_r;
    need_pad_nxt = need_pad_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_last_word) begin
            need_pad_nxt = (in_byte_count >= 4'd8);
            ret_nxt = ST_PAD;
          end else begin
            ret_nxt = ST_IDLE;
          end
          if (stat.block_full) state_nxt = ST_ROUND;
          else state_nxt = ret_nxt;
        end
      end
      ST_PAD: begin
        need_pad_nxt = 1'b0;
        if (!need_pad_r && stat.fill == 4'd14) begin
          state_nxt = ST_LEN_HI;
        end else if (stat.block_full) begin
          ret_nxt   = ST_PAD;
          state_nxt = ST_ROUND;
        end
      end
      ST_LEN_HI: state_nxt = ST_LEN_LO;
      ST_LEN_LO: begin
        ret_nxt   = ST_OUT;
        state_nxt = ST_ROUND;
      end
      ST_ROUND: if (stat.rounds_done) state_nxt = ST_ADD;
      ST_ADD: state_nxt = ret_r;
      ST_OUT: if (out_ready && stat.out_done) begin
        state_nxt = ST_IDLE;
        ret_nxt   = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.wsrc  = WSRC_INPUT;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.push  = in_valid;
        cmd.start = in_valid && stat.block_full;
      end
      ST_PAD: begin
        cmd.push  = !(!need_pad_r && stat.fill == 4'd14);
        cmd.wsrc  = need_pad_r ? WSRC_PAD : WSRC_ZERO;
        cmd.start = cmd.push && stat.block_full;
      end
      ST_LEN_HI: begin
        cmd.push = 1'b1;
        cmd.wsrc = WSRC_ZERO;
      end
      ST_LEN_LO: begin
        cmd.push  = 1'b1;
        cmd.wsrc  = WSRC_LEN;
        cmd.start = 1'b1;
      end
      ST_ROUND: cmd.round = 1'b1;
      ST_ADD:   cmd.add = 1'b1;
      ST_OUT: begin
        out_valid   = 1'b1;
        cmd.out_adv = out_ready;
        cmd.clear   = out_ready && stat.out_done;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

@@ sv/sha512_dp.sv @@
// Datapath: message buffer, schedule window, round unit, chaining value.
`timescale 1ns / 1ps
`default_nettype none
module sha512_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sha512_pkg::cmd_t  cmd,
  input  wire logic [63:0]       in_message_word,
  input  wire logic [3:0]        in_byte_count,
  input  wire logic              in_last_word,
  output sha512_pkg::stat_t      stat,
  output logic [63:0]            out_digest_word,
  output logic [2:0]             out_digest_index,
  output logic                   out_digest_last
);
  import sha512_pkg::*;

  logic [63:0] w_r [16];
  logic [63:0] v_r [8];
  logic [63:0] h_r [8];
  logic [3:0]  fill_r;
  logic [6:0]  rnd_r;
  logic [2:0]  oidx_r;
  logic [63:0] len_r;
  logic [63:0] push_word, wnew, s0w, s1w, t1, t2, sig1, sig0, ch, maj;
  logic [3:0]  nb;
  logic [63:0] keep;
  logic [6:0]  sh;

  always_comb begin
    nb   = (in_byte_count > 4'd8) ? 4'd8 : in_byte_count;
    sh   = 7'(64 - 8 * int'(nb));
    keep = (nb == 4'd0) ? 64'd0 : (~64'd0 << sh);
    unique case (cmd.wsrc)
      WSRC_INPUT: begin
        if (in_last_word && nb != 4'd8)
          push_word = (in_message_word & keep) | (64'(PadByte) << (7'd56 - 7'(8 * int'(nb))));
        else
          push_word = in_message_word;
      end
      WSRC_PAD:  push_word = {PadByte, 56'd0};
      WSRC_LEN:  push_word = len_r;
      default:   push_word = '0;
    endcase
  end

  always_comb begin
    s0w  = rotr(w_r[1], 1) ^ rotr(w_r[1], 8) ^ (w_r[1] >> 7);
    s1w  = rotr(w_r[14], 19) ^ rotr(w_r[14], 61) ^ (w_r[14] >> 6);
    wnew = w_r[0] + s0w + w_r[9] + s1w;
    sig1 = rotr(v_r[4], 14) ^ rotr(v_r[4], 18) ^ rotr(v_r[4], 41);
    ch   = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1   = v_r[7] + sig1 + ch + RoundK[rnd_r] + w_r[0];
    sig0 = rotr(v_r[0], 28) ^ rotr(v_r[0], 34) ^ rotr(v_r[0], 39);
    maj  = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t2   = sig0 + maj;
  end

  // window shifts: w_r[0] is always the current round word
  always_ff @(posedge clk) begin
    if (cmd.push) w_r[fill_r] <= push_word;
    if (cmd.round) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i + 1];
      w_r[15] <= wnew;
    end
    if (cmd.start) for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
    if (cmd.round) begin
      v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      for (int i = 0; i < 8; i++) h_r[i] <= InitHash[i];
      fill_r <= '0;
      rnd_r  <= '0;
      oidx_r <= '0;
      len_r  <= '0;
    end else begin
      if (cmd.push) fill_r <= fill_r + 4'd1;
      if (cmd.push && cmd.wsrc == WSRC_INPUT)
        len_r <= len_r + (in_last_word ? 64'({nb, 3'd0}) : 64'd64);
      if (cmd.round) rnd_r <= (rnd_r == 7'(Rounds - 1)) ? 7'd0 : rnd_r + 7'd1;
      if (cmd.add) for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
      if (cmd.out_adv) oidx_r <= oidx_r + 3'd1;
    end
  end

  assign stat.block_full  = (fill_r == 4'(BlockWords - 1));
  assign stat.fill        = fill_r;
  assign stat.rounds_done = (rnd_r == 7'(Rounds - 1));
  assign stat.out_done    = (oidx_r == 3'd7);
  assign out_digest_word  = h_r[oidx_r];
  assign out_digest_index = oidx_r;
  assign out_digest_last  = (oidx_r == 3'd7);
endmodule
`default_nettype wire
